>>> hw/rtl/sobm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobm_pkg
// Shared constants and types for the Sobel magnitude normalizer.
// ----------------------------------------------------------------------------
package sobm_pkg;

   localparam int MAG_W    = 15;
   localparam int CSR_W    = 11;
   localparam int CSR_IDX_W = 2;

   localparam logic [MAG_W-1:0] MAG_ONE      = 15'd16;
   localparam logic [MAG_W-1:0] MAG_ALL_ONES = 15'h7FFF;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BRIGHTNESS = 2'd2;

   localparam logic OP_MEASURE = 1'b0;
   localparam logic OP_OUTPUT  = 1'b1;

   localparam logic KIND_PIXEL   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic             flat;
      logic [MAG_W-1:0] max_mag;
      logic [MAG_W-1:0] min_mag;
      logic [7:0]       value;
      logic [9:0]       col;
      logic [9:0]       row;
   } rsp_data_type;

endpackage

>>> hw/rtl/sobm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobm_ram
// Generic single-clock RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sobm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

>>> hw/rtl/sobel_magnitude_normalizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_magnitude_normalizer
// Two-pass 3x3 Sobel edge magnitude with min-max normalization.
// ----------------------------------------------------------------------------
// Each frame is streamed twice in raster order: a measure pass (tuser 0) that
// ends in a summary transaction carrying the frame's least and greatest
// magnitude, then an output pass (tuser 1) that returns one normalized value
// per interior pixel. Rows r-2 and r-1 live in one line RAM read and written
// back once per pixel. Pixels are processed one at a time: a border pixel
// goes through line RAM read and finish, an interior pixel of the measure pass
// through line RAM read, squaring and a 15-step bit-pair square root, and one
// of the output pass may add an 8-step divider. A result waiting on rsp_tready
// does not stop the next pixel from being accepted; the result after it
// holds the block until the waiting one drains.
module sobel_magnitude_normalizer #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [sobm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sobm_pkg::CSR_W-1:0]    csr_wdata,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,  // pixel
   input  logic                          req_tuser,  // op
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [63:0]                   rsp_tdata,  // row, col, value, min_mag, max_mag, flat
   output logic                          rsp_tuser   // kind
);
   import sobm_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int DW = (CW + 1 > CSR_W) ? CW + 1 : CSR_W;
   localparam int RDW = (RW + 1 > CSR_W) ? RW + 1 : CSR_W;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_SQR  = 3'd2;
   localparam logic [2:0] ST_ROOT = 3'd3;
   localparam logic [2:0] ST_EVAL = 3'd4;
   localparam logic [2:0] ST_DIV  = 3'd5;
   localparam logic [2:0] ST_FIN  = 3'd6;

   logic [2:0] state_ff, state_in;

   logic [CSR_W-1:0] width_ff, height_ff;
   logic [7:0]       bright_ff;

   logic [CW-1:0] col_count_ff, col_count_in;
   logic [RW-1:0] row_count_ff, row_count_in;
   logic [CW-1:0] c_ff;
   logic [RW-1:0] r_ff;
   logic          op_ff, last_ff;
   logic [7:0]    px_ff;
   logic [MAG_W-1:0] min_ff, max_ff;
   logic [7:0]    win_ff [9];

   logic [29:0]   rad_ff;
   logic [16:0]   rem_ff;
   logic [MAG_W-1:0] root_ff;
   logic [3:0]    step_ff;
   logic [22:0]   num_ff;
   logic [22:0]   den_ff;
   logic [7:0]    quo_ff;
   logic          res_ff;
   logic          kind_ff;

   logic          rsp_valid_ff;
   logic          rsp_kind_ff;
   rsp_data_type  rsp_data_ff;

   logic [15:0]   ram_rd;
   logic          ram_we;

   logic [DW-1:0]  w_dim;
   logic [RDW-1:0] h_dim;
   logic           acc, interior, flat_now;
   logic signed [10:0] gx, gy;
   logic [16:0]   trial, rem_shift;
   logic [15:0]   row_m1, col_m1;

   sobm_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_lines (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(c_ff),
      .wr_data({ram_rd[7:0], px_ff}),
      .rd_addr(col_count_ff),
      .rd_data(ram_rd)
   );

   always_comb begin
      if (width_ff == '0) begin
         w_dim = DW'(1);
      end else if (DW'(width_ff) > DW'(MAX_WIDTH)) begin
         w_dim = DW'(MAX_WIDTH);
      end else begin
         w_dim = DW'(width_ff);
      end
      if (height_ff == '0) begin
         h_dim = RDW'(1);
      end else if (RDW'(height_ff) > RDW'(MAX_HEIGHT)) begin
         h_dim = RDW'(MAX_HEIGHT);
      end else begin
         h_dim = RDW'(height_ff);
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign acc        = req_tvalid && req_tready;
   assign ram_we     = (state_ff == ST_READ);
   assign interior   = (r_ff >= RW'(2)) && (c_ff >= CW'(2));
   assign flat_now   = ({1'b0, max_ff} < ({1'b0, min_ff} + {1'b0, MAG_ONE}));

   assign gx = (11'(win_ff[2]) + 11'({win_ff[5], 1'b0}) + 11'(win_ff[8]))
             - (11'(win_ff[0]) + 11'({win_ff[3], 1'b0}) + 11'(win_ff[6]));
   assign gy = (11'(win_ff[6]) + 11'({win_ff[7], 1'b0}) + 11'(win_ff[8]))
             - (11'(win_ff[0]) + 11'({win_ff[1], 1'b0}) + 11'(win_ff[2]));

   assign rem_shift = {rem_ff[14:0], rad_ff[29:28]};
   assign trial     = {root_ff, 2'b01};
   assign row_m1    = 16'(r_ff) - 16'd1;
   assign col_m1    = 16'(c_ff) - 16'd1;

   always_comb begin
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      if (acc) begin
         if (DW'(col_count_ff) + DW'(1) >= w_dim) begin
            col_count_in = '0;
            row_count_in = (RDW'(row_count_ff) + RDW'(1) >= h_dim) ? '0 : row_count_ff + RW'(1);
         end else begin
            col_count_in = col_count_ff + CW'(1);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (acc) state_in = ST_READ;
         ST_READ: state_in = interior ? ST_SQR : ST_FIN;
         ST_SQR:  state_in = ST_ROOT;
         ST_ROOT: if (step_ff == 4'd14) state_in = ST_EVAL;
         ST_EVAL: begin
            if (op_ff == OP_OUTPUT && !flat_now && root_ff > min_ff && root_ff < max_ff) begin
               state_in = ST_DIV;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_DIV:  if (step_ff == 4'd7) state_in = ST_FIN;
         ST_FIN:  if (!res_ff || !rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         width_ff     <= 11'd1024;
         height_ff    <= 11'd1024;
         bright_ff    <= 8'd255;
         col_count_ff <= '0;
         row_count_ff <= '0;
         min_ff       <= MAG_ALL_ONES;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         res_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_IMAGE_WIDTH:    width_ff  <= csr_wdata;
               CSR_IMAGE_HEIGHT:   height_ff <= csr_wdata;
               CSR_MAX_BRIGHTNESS: bright_ff <= csr_wdata[7:0];
               default: ;
            endcase
         end
         if (acc && req_tuser == OP_MEASURE && row_count_ff == '0 && col_count_ff == '0) begin
            min_ff <= MAG_ALL_ONES;
            max_ff <= '0;
         end
         if (state_ff == ST_EVAL && op_ff == OP_MEASURE) begin
            if (root_ff < min_ff) min_ff <= root_ff;
            if (root_ff > max_ff) max_ff <= root_ff;
         end
         if (state_ff == ST_READ) begin
            res_ff <= (interior && op_ff == OP_OUTPUT) || (op_ff == OP_MEASURE && last_ff);
         end
         if (state_ff == ST_FIN && res_ff && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         c_ff    <= col_count_ff;
         r_ff    <= row_count_ff;
         op_ff   <= req_tuser;
         px_ff   <= req_tdata;
         last_ff <= (DW'(col_count_ff) + DW'(1) >= w_dim)
                 && (RDW'(row_count_ff) + RDW'(1) >= h_dim);
      end
      if (state_ff == ST_READ) begin
         for (int k = 0; k < 3; k++) begin
            win_ff[k*3]     <= win_ff[k*3 + 1];
            win_ff[k*3 + 1] <= win_ff[k*3 + 2];
         end
         win_ff[2] <= ram_rd[15:8];
         win_ff[5] <= ram_rd[7:0];
         win_ff[8] <= px_ff;
         kind_ff   <= (op_ff == OP_MEASURE && last_ff) ? KIND_SUMMARY : KIND_PIXEL;
         quo_ff    <= '0;
         root_ff   <= '0;
      end
      if (state_ff == ST_SQR) begin
         rad_ff  <= {1'b0, (21'(gx) * 21'(gx)) + (21'(gy) * 21'(gy)), 8'd0};
         rem_ff  <= '0;
         root_ff <= '0;
         step_ff <= '0;
      end
      if (state_ff == ST_ROOT) begin
         rad_ff  <= {rad_ff[27:0], 2'b00};
         step_ff <= step_ff + 4'd1;
         if (rem_shift >= trial) begin
            rem_ff  <= rem_shift - trial;
            root_ff <= {root_ff[MAG_W-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_shift;
            root_ff <= {root_ff[MAG_W-2:0], 1'b0};
         end
      end
      if (state_ff == ST_EVAL) begin
         num_ff  <= 23'(bright_ff * (root_ff - min_ff));
         den_ff  <= {1'b0, max_ff - min_ff, 7'd0};
         step_ff <= '0;
         if (flat_now || root_ff <= min_ff) begin
            quo_ff <= '0;
         end else begin
            quo_ff <= bright_ff;
         end
      end
      if (state_ff == ST_DIV) begin
         step_ff <= step_ff + 4'd1;
         den_ff  <= {1'b0, den_ff[22:1]};
         if (num_ff >= den_ff) begin
            num_ff <= num_ff - den_ff;
            quo_ff <= {quo_ff[6:0], 1'b1};
         end else begin
            quo_ff <= {quo_ff[6:0], 1'b0};
         end
      end
      if (state_ff == ST_FIN && res_ff && (!rsp_valid_ff || rsp_tready)) begin
         rsp_kind_ff <= kind_ff;
         if (kind_ff == KIND_SUMMARY) begin
            rsp_data_ff.row     <= '0;
            rsp_data_ff.col     <= '0;
            rsp_data_ff.value   <= '0;
            rsp_data_ff.min_mag <= min_ff;
            rsp_data_ff.max_mag <= max_ff;
            rsp_data_ff.flat    <= flat_now;
         end else begin
            rsp_data_ff.row     <= row_m1[9:0];
            rsp_data_ff.col     <= col_m1[9:0];
            rsp_data_ff.value   <= quo_ff;
            rsp_data_ff.min_mag <= '0;
            rsp_data_ff.max_mag <= '0;
            rsp_data_ff.flat    <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {5'd0, rsp_data_ff};

`ifndef SYNTH
   a_summary_flat: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_SUMMARY) |->
      (rsp_tdata[58] == ({1'b0, rsp_tdata[57:43]} < ({1'b0, rsp_tdata[42:28]} + 16'd16))))
      else $error("summary flat flag disagrees with min and max");
   a_value_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && res_ff && kind_ff == KIND_PIXEL) |-> (quo_ff <= bright_ff))
      else $error("normalized value above full scale");
   a_root_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT) |-> (step_ff <= 4'd14))
      else $error("square root overran its step count");
`endif

endmodule

>>> sim/sobel_magnitude_normalizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_magnitude_normalizer_tb
// Self-checking bench for the two-pass Sobel magnitude normalizer.
// ----------------------------------------------------------------------------
// Streams frames through a measure pass and an output pass. A behavioral
// edge-magnitude predictor tracks the line stores, the 3x3 window and the
// running min/max. Each accepted pixel that is due a transaction adds it to a
// queue. The queue is checked field by field against rsp transactions.
// A directed table runs first, then random frames across four
// sender/receiver idling phases with several geometry settings.
// ----------------------------------------------------------------------------
module sobel_magnitude_normalizer_tb;
   import sobm_pkg::*;

   localparam int LINE_DEPTH = 1024;
   localparam int SETTLE     = 40;

   typedef struct {
      logic         kind;
      rsp_data_type data;
   } edge_result_type;

   typedef struct {
      logic         op;
      logic [7:0]   pixel;
      bit           typed;
      logic         kind;
      rsp_data_type data;
   } edge_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_IMAGE_WIDTH;
   logic [CSR_W-1:0]     csr_wdata = '0;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata = '0;   // pixel
   logic                 req_tuser = 1'b0; // op
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [63:0]          rsp_tdata;        // row, col, value, min_mag, max_mag, flat
   logic                 rsp_tuser;        // kind

   edge_result_type edge_results_q[$];
   int              error_count = 0;
   int              send_idle = 0;
   int              recv_stall = 0;

   // predictor state
   logic [7:0] upper_ln[LINE_DEPTH];
   logic [7:0] middle_ln[LINE_DEPTH];
   logic [7:0] win[9];
   int unsigned row_pos = 0;
   int unsigned col_pos = 0;
   int unsigned mag_min = 32'h7FFF;
   int unsigned mag_max = 0;
   int unsigned cfg_width = 1024;
   int unsigned cfg_height = 1024;
   int unsigned cfg_bright = 255;

   logic [7:0] frame_px[];

   sobel_magnitude_normalizer uut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always #6 clock = ~clock;

   initial begin
      #50_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic int unsigned int_sqrt(input int unsigned v);
      int unsigned r;
      int unsigned b;
      r = 0;
      b = 32'h4000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic int unsigned clamp_dim(input int unsigned v);
      if (v == 0) return 1;
      return (v > LINE_DEPTH) ? LINE_DEPTH : v;
   endfunction

   // advance the edge model by one pixel; returns 1 when a transaction is due
   function automatic bit edge_predict(input logic op, input logic [7:0] px,
                                       output edge_result_type res);
      int unsigned w, h, r, c, m, v, s;
      int gx, gy;
      logic [7:0] up, mid;
      bit flat, due;
      w = clamp_dim(cfg_width);
      h = clamp_dim(cfg_height);
      r = row_pos;
      c = col_pos;
      up = '0;
      mid = '0;
      due = 0;
      res.kind = KIND_PIXEL;
      res.data = '0;
      if (op == OP_MEASURE && r == 0 && c == 0) begin
         mag_min = 32'h7FFF;
         mag_max = 0;
      end
      if (c < LINE_DEPTH) begin
         up = upper_ln[c];
         mid = middle_ln[c];
         upper_ln[c] = mid;
         middle_ln[c] = px;
      end
      for (int k = 0; k < 3; k++) begin
         win[k*3] = win[k*3+1];
         win[k*3+1] = win[k*3+2];
      end
      win[2] = up;
      win[5] = mid;
      win[8] = px;
      flat = mag_max < mag_min + 16;
      if (r >= 2 && c >= 2) begin
         gx = (win[2] + 2*win[5] + win[8]) - (win[0] + 2*win[3] + win[6]);
         gy = (win[6] + 2*win[7] + win[8]) - (win[0] + 2*win[1] + win[2]);
         s = gx*gx + gy*gy;
         m = int_sqrt(s * 256);
         if (op == OP_MEASURE) begin
            if (m < mag_min) mag_min = m;
            if (m > mag_max) mag_max = m;
         end else begin
            if (flat || m <= mag_min) v = 0;
            else if (m >= mag_max) v = cfg_bright;
            else v = (cfg_bright * (m - mag_min)) / (mag_max - mag_min);
            res.data.row = 10'(r - 1);
            res.data.col = 10'(c - 1);
            res.data.value = 8'(v);
            due = 1;
         end
      end
      if (op == OP_MEASURE && c + 1 >= w && r + 1 >= h) begin
         res.kind = KIND_SUMMARY;
         res.data = '0;
         res.data.min_mag = MAG_W'(mag_min);
         res.data.max_mag = MAG_W'(mag_max);
         res.data.flat = mag_max < mag_min + 16;
         due = 1;
      end
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
      return due;
   endfunction

   task automatic report(input string what, input int got, input int want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // hold the pixel until accepted, then log its expected transaction if one is due
   task automatic push_pixel(input logic op, input logic [7:0] px,
                             input bit typed = 0,
                             input edge_result_type typed_res = '{default: '0});
      edge_result_type res;
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= px;
      do @(posedge clock); while (!req_tready);
      if (edge_predict(op, px, res))
         edge_results_q.push_back(typed ? typed_res : res);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (edge_results_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_geometry(input int unsigned w, input int unsigned h,
                               input int unsigned bright);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= CSR_W'(w);
      @(posedge clock);
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_wdata <= CSR_W'(h);
      @(posedge clock);
      csr_index <= CSR_MAX_BRIGHTNESS;
      csr_wdata <= CSR_W'(bright);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_width = w & 11'h7FF;
      cfg_height = h & 11'h7FF;
      cfg_bright = bright & 8'hFF;
   endtask

   // style 0 full random, 1 constant, 2 low contrast, 3 ramp
   task automatic build_frame(input int style);
      int unsigned n, base;
      n = clamp_dim(cfg_width) * clamp_dim(cfg_height);
      frame_px = new[n];
      base = $urandom_range(255);
      foreach (frame_px[i]) begin
         case (style)
            0: frame_px[i] = 8'($urandom);
            1: frame_px[i] = 8'(base);
            2: frame_px[i] = 8'(base) ^ 8'($urandom_range(1));
            default: frame_px[i] = 8'(i * 17 + base);
         endcase
      end
   endtask

   // mode 0 measure, 1 output, 2 mixed op per pixel
   task automatic stream_frame(input int mode);
      foreach (frame_px[i])
         push_pixel(mode == 2 ? logic'($urandom_range(1)) : logic'(mode), frame_px[i]);
   endtask

   task automatic run_random_frame;
      int unsigned w, h, b, sel;
      sel = $urandom_range(99);
      if (sel < 8) begin
         w = $urandom_range(2); h = $urandom_range(3, 5);
      end else if (sel < 14) begin
         w = $urandom_range(3, 6); h = $urandom_range(2);
      end else begin
         w = $urandom_range(3, 8); h = $urandom_range(3, 5);
      end
      sel = $urandom_range(9);
      b = (sel == 0) ? 1 : (sel == 1) ? 255 : $urandom_range(1, 255);
      set_geometry(w, h, b);
      build_frame($urandom_range(3));
      sel = $urandom_range(99);
      if (sel < 75) begin
         stream_frame(0);
         stream_frame(1);
      end else if (sel < 87) begin
         stream_frame(0);
         build_frame($urandom_range(3));
         stream_frame(1);
      end else begin
         stream_frame(2);
      end
      drain();
   endtask

   // receiver: random backpressure and per-field compare
   always @(posedge clock) begin
      edge_result_type want;
      rsp_data_type got;
      rsp_tready <= ($urandom_range(99) >= recv_stall);
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_data_type'(rsp_tdata[$bits(rsp_data_type)-1:0]);
         if (edge_results_q.size() == 0) begin
            report("unexpected transaction", rsp_tuser, 0);
         end else begin
            want = edge_results_q.pop_front();
            if (rsp_tuser !== want.kind) report("kind", rsp_tuser, want.kind);
            if (got.row !== want.data.row) report("row", got.row, want.data.row);
            if (got.col !== want.data.col) report("col", got.col, want.data.col);
            if (got.value !== want.data.value) report("value", got.value, want.data.value);
            if (got.min_mag !== want.data.min_mag)
               report("min_mag", got.min_mag, want.data.min_mag);
            if (got.max_mag !== want.data.max_mag)
               report("max_mag", got.max_mag, want.data.max_mag);
            if (got.flat !== want.data.flat) report("flat", got.flat, want.data.flat);
         end
      end
   end

   initial begin
      edge_row_type rows[$];
      edge_row_type row_item;
      edge_result_type typed_res;
      int idle_pct[4];
      int stall_pct[4];
      idle_pct = '{0, 79, 0, 24};
      stall_pct = '{0, 0, 79, 24};
      foreach (win[k]) win[k] = '0;
      for (int i = 0; i < LINE_DEPTH; i++) begin
         upper_ln[i] = '0;
         middle_ln[i] = '0;
      end

      // zero frame: flat summary, then right-edge frame through both passes
      for (int i = 0; i < 9; i++) begin
         row_item = '{op: OP_MEASURE, pixel: 8'd0, typed: (i == 8),
                      kind: KIND_SUMMARY, data: '0};
         row_item.data.flat = 1'b1;
         rows.push_back(row_item);
      end
      for (int p = 0; p < 3; p++)
         for (int i = 0; i < 9; i++) begin
            row_item = '{op: (p == 1) ? OP_MEASURE : OP_OUTPUT,
                         pixel: (i % 3 == 2) ? 8'd255 : 8'd0,
                         typed: 0, kind: KIND_PIXEL, data: '0};
            rows.push_back(row_item);
         end
      // output pass of a zero frame against a flat summary gives value 0
      for (int i = 0; i < 9; i++) begin
         row_item = '{op: OP_OUTPUT, pixel: 8'd0, typed: 0, kind: KIND_PIXEL, data: '0};
         rows.push_back(row_item);
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_geometry(3, 3, 255);
      foreach (rows[i]) begin
         typed_res.kind = rows[i].kind;
         typed_res.data = rows[i].data;
         push_pixel(rows[i].op, rows[i].pixel, rows[i].typed, typed_res);
      end
      drain();
      set_geometry(3, 3, 1);
      foreach (rows[i]) push_pixel(rows[i].op, rows[i].pixel);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         send_idle = idle_pct[ph];
         recv_stall = stall_pct[ph];
         for (int f = 0; f < 3; f++) run_random_frame();
      end

      drain();
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

>>> sobel_magnitude_normalizer.f
hw/rtl/sobm_pkg.sv
hw/rtl/sobm_ram.sv
hw/rtl/sobel_magnitude_normalizer.sv
sim/sobel_magnitude_normalizer_tb.sv
